FILE: sv/dbdsr_pkg.sv
// Shared types and constants for the digit-by-digit square root block.
// No dependencies; imported by the controller, the datapath and the top level.
package dbdsr_pkg;

  // Fixed field and state widths.
  localparam int RadicandW  = 31;
  localparam int RootW      = 26;
  localparam int RemW       = 40;
  localparam int CountW     = 17;
  localparam int DigitIdxW  = 2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INT,
    ST_SETUP,
    ST_FRAC,
    ST_FINISH
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Take a new radicand, start the integer part.
    logic step;    // Subtract the odd term and count it.
    logic commit;  // Fold the digit count into the root.
    logic setup;   // Scale the remainder and seed the odd term for a fraction digit.
    logic finish;  // Scale the root to thousandths into the output register.
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fits;    // The current odd term does not exceed the remainder.
  } dp_status_t;

endpackage

FILE: sv/dbdsr_datapath.sv
// Datapath of the square root: remainder, odd term, digit count, root and result.
// Depends on dbdsr_pkg; driven by dbdsr_controller commands.
module dbdsr_datapath import dbdsr_pkg::*; #(
  parameter int RADICAND_BITS   = 31,
  parameter int FRACTION_DIGITS = 3
) (
  input  logic                 clk,
  input  logic [RadicandW-1:0] radicand,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic [RootW-1:0]     root_thousandths
);

  localparam logic [RadicandW-1:0] RadMask =
    RadicandW'((64'd1 << RADICAND_BITS) - 64'd1);

  logic [RemW-1:0]   remainder;
  logic [RemW-1:0]   odd_term;
  logic [CountW-1:0] digit_counter;
  logic [RootW-1:0]  root_so_far;
  logic [RemW:0]     diff;
  logic [RootW-1:0]  root_committed;
  logic [RemW-1:0]   rem_scaled;
  logic [RemW-1:0]   odd_seed;
  logic [RemW-1:0]   root_wide;
  logic [RootW-1:0]  root_scaled;

  // One wide subtract serves both the compare and the new remainder.
  assign diff        = {1'b0, remainder} - {1'b0, odd_term};
  assign status.fits = ~diff[RemW];

  // Shift-and-add forms of the decimal scalings.
  assign root_committed = (root_so_far << 3) + (root_so_far << 1)
                        + RootW'(digit_counter);
  assign rem_scaled     = (remainder << 6) + (remainder << 5) + (remainder << 2);
  assign root_wide      = RemW'(root_so_far);
  assign odd_seed       = (root_wide << 4) + (root_wide << 2) + RemW'(1);

  // Pad missing fraction digits with zeros so the result stays in thousandths.
  always_comb begin
    unique case (FRACTION_DIGITS)
      1:       root_scaled = (root_so_far << 6) + (root_so_far << 5) + (root_so_far << 2);
      2:       root_scaled = (root_so_far << 3) + (root_so_far << 1);
      default: root_scaled = root_so_far;
    endcase
  end

  // Working registers; payload only, so no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remainder     <= RemW'(radicand & RadMask);
      odd_term      <= RemW'(1);
      digit_counter <= '0;
      root_so_far   <= '0;
    end else if (cmd.step) begin
      remainder     <= diff[RemW-1:0];
      odd_term      <= odd_term + RemW'(2);
      digit_counter <= digit_counter + CountW'(1);
    end else if (cmd.commit) begin
      root_so_far   <= root_committed;
    end else if (cmd.setup) begin
      remainder     <= rem_scaled;
      odd_term      <= odd_seed;
      digit_counter <= '0;
    end
    if (cmd.finish) begin
      root_thousandths <= root_scaled;
    end
  end

endmodule

FILE: sv/dbdsr_controller.sv
// Sequencer for the square root: integer part, fraction digits, result handoff.
// Depends on dbdsr_pkg; commands dbdsr_datapath and owns both handshakes.
module dbdsr_controller import dbdsr_pkg::*; #(
  parameter int FRACTION_DIGITS = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [DigitIdxW-1:0] LastDigit = DigitIdxW'(FRACTION_DIGITS - 1);

  ctrl_state_t          state, state_next;
  logic [DigitIdxW-1:0] digit, digit_next;
  logic                 out_valid_next;

  // State, digit index and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      digit     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      digit     <= digit_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    digit_next     = digit;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid & out_stall;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_INT;
        end
      end
      ST_INT: begin
        if (status.fits) begin
          cmd.step = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          digit_next = '0;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_FRAC;
      end
      ST_FRAC: begin
        if (status.fits) begin
          cmd.step = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          if (digit == LastDigit) begin
            state_next = ST_FINISH;
          end else begin
            digit_next = digit + DigitIdxW'(1);
            state_next = ST_SETUP;
          end
        end
      end
      ST_FINISH: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid || !out_stall) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/digit_by_digit_square_root_top.sv
// Digit-by-digit square root, result in thousandths. One item at a time.
// Sequence: the integer part by odd-term subtraction, then per fraction digit a setup
// step and its subtract steps, then a finish step into the output register.
// The odd-term subtract loop sets the rate.
// A finished beat waits in the output register while the next radicand is taken.
// Reset (rst, synchronous) returns the sequencer to idle and clears out_valid.
module digit_by_digit_square_root_top import dbdsr_pkg::*; #(
  parameter int RADICAND_BITS   = 31,
  parameter int FRACTION_DIGITS = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [RadicandW-1:0] radicand,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RootW-1:0]     root_thousandths
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  dbdsr_controller #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic.
  dbdsr_datapath #(
    .RADICAND_BITS  (RADICAND_BITS),
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_datapath (
    .clk             (clk),
    .radicand        (radicand),
    .cmd             (cmd),
    .status          (status),
    .root_thousandths(root_thousandths)
  );

endmodule

FILE: sv/dbdsr_checker.sv
// Port-level checks for the square root block, bound to its top level.
// Depends on dbdsr_pkg for field widths.
module dbdsr_checker import dbdsr_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [RadicandW-1:0] radicand,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [RootW-1:0]     root_thousandths
);

  // A stalled result beat stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(root_thousandths))
    else $error("stalled result beat changed");

  // An accepted radicand keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in work");

  // A new result appears only as the block returns to idle.
  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall && $past(in_stall))
    else $error("result appeared outside the end of an item");

  // The root of a 31-bit value never exceeds 46340999 thousandths.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> root_thousandths <= RootW'(46340999))
    else $error("result out of range");

endmodule

bind digit_by_digit_square_root_top dbdsr_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .radicand        (radicand),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .root_thousandths(root_thousandths)
);
